// ===== rtl/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants for the beacon sync supervisor timer.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

    // item codes
    localparam logic [1:0] OP_FAST_TICK = 2'd0;
    localparam logic [1:0] OP_SLOW_TICK = 2'd1;
    localparam logic [1:0] OP_PKT_IRQ   = 2'd2;

    // packet types
    localparam logic [1:0] PKT_BEACON   = 2'd0;
    localparam logic [1:0] PKT_JOIN_ACK = 2'd1;
    localparam logic [1:0] PKT_REJOIN   = 2'd2;

    // handler events
    localparam logic [1:0] HE_NONE     = 2'd0;
    localparam logic [1:0] HE_BEACON   = 2'd1;
    localparam logic [1:0] HE_JOIN_ACK = 2'd2;
    localparam logic [1:0] HE_REJOIN   = 2'd3;

    // register indexes
    localparam logic [2:0] REG_POWER_MODE   = 3'd0;
    localparam logic [2:0] REG_BEACON_PER   = 3'd1;
    localparam logic [2:0] REG_PRE_WAKE     = 3'd2;
    localparam logic [2:0] REG_COLLECT_PER  = 3'd3;
    localparam logic [2:0] REG_COLLECT_EN   = 3'd4;
    localparam logic [2:0] REG_CAL_PER      = 3'd5;
    localparam logic [2:0] REG_RRESET_LIMIT = 3'd6;
    localparam logic [2:0] REG_REBOOT_LIMIT = 3'd7;

    localparam int ADDR_W = 5;

    // reset values of the registers
    localparam logic [15:0] RST_BEACON_PER   = 16'd1000;
    localparam logic [31:0] RST_PRE_WAKE     = 32'd990;
    localparam logic [15:0] RST_COLLECT_PER  = 16'd5000;
    localparam logic [15:0] RST_CAL_PER      = 16'd600;
    localparam logic [15:0] RST_RRESET_LIMIT = 16'd50;
    localparam logic [15:0] RST_REBOOT_LIMIT = 16'd300;

    typedef struct packed {
        logic [1:0] opcode;
        logic       packet_valid;
        logic [1:0] packet_type;
        logic       collect_active;
        logic       road_empty;
    } t_item;

    typedef struct packed {
        logic        reboot_request;
        logic        radio_reset_task;
        logic        radio_reset_now;
        logic        wake_radio;
        logic        enable_radio_irq;
        logic        collect_data;
        logic        calibrate;
        logic        get_variance;
        logic [1:0]  handler_event;
        logic        arm_frame_timer;
        logic        packet_ok;
    } t_result;

    typedef struct packed {
        logic        power_mode;
        logic [15:0] bcn_interval;
        logic [31:0] pre_beacon_wake;
        logic [15:0] coll_interval;
        logic        collect_enable;
        logic [15:0] calib_interval;
        logic [15:0] radio_reset_limit;
        logic [15:0] reboot_limit;
    } t_cfg;

    typedef struct packed {
        logic [31:0] frame_ticks;
        logic [15:0] collect_ticks;
        logic [15:0] silence_ticks;
        logic [15:0] cal_ticks;
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/bss_in_if.sv =====
// ----------------------------------------------------------------------------
// bss_in_if
// Event channel: valid/ready handshake with the event fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface bss_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       packet_valid;
    logic [1:0] packet_type;
    logic       collect_active;
    logic       road_empty;

    modport source (output valid, opcode, packet_valid, packet_type, collect_active,
                    road_empty, input ready);
    modport sink   (input valid, opcode, packet_valid, packet_type, collect_active,
                    road_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/bss_out_if.sv =====
// ----------------------------------------------------------------------------
// bss_out_if
// Result channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface bss_out_if;
    logic       valid;
    logic       ready;
    logic       reboot_request;
    logic       radio_reset_task;
    logic       radio_reset_now;
    logic       wake_radio;
    logic       enable_radio_irq;
    logic       collect_data;
    logic       calibrate;
    logic       get_variance;
    logic [1:0] handler_event;
    logic       arm_frame_timer;
    logic       packet_ok;

    modport source (output valid, reboot_request, radio_reset_task, radio_reset_now,
                    wake_radio, enable_radio_irq, collect_data, calibrate, get_variance,
                    handler_event, arm_frame_timer, packet_ok, input ready);
    modport sink   (input valid, reboot_request, radio_reset_task, radio_reset_now,
                    wake_radio, enable_radio_irq, collect_data, calibrate, get_variance,
                    handler_event, arm_frame_timer, packet_ok, output ready);
endinterface

`default_nettype wire

// ===== rtl/bss_step.sv =====
// ----------------------------------------------------------------------------
// bss_step
// Next-state and request logic for one event against the current counters.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_step (
    input  var bss_pkg::t_item   i_item,
    input  var bss_pkg::t_cfg    i_cfg,
    input  var bss_pkg::t_state  i_state,
    output bss_pkg::t_state      o_state,
    output bss_pkg::t_result     o_result
);
    import bss_pkg::*;

    logic [31:0] frame_inc;
    logic [15:0] collect_inc;
    logic [15:0] silence_inc;
    logic [15:0] cal_inc;
    logic [31:0] loss_point;
    logic [31:0] reboot_point;

    // saturating increments
    assign frame_inc   = (i_state.frame_ticks == '1)   ? i_state.frame_ticks
                                                       : i_state.frame_ticks + 32'd1;
    assign collect_inc = (i_state.collect_ticks == '1) ? i_state.collect_ticks
                                                       : i_state.collect_ticks + 16'd1;
    assign silence_inc = (i_state.silence_ticks == '1) ? i_state.silence_ticks
                                                       : i_state.silence_ticks + 16'd1;
    assign cal_inc     = (i_state.cal_ticks == '1)     ? i_state.cal_ticks
                                                       : i_state.cal_ticks + 16'd1;

    // four and eight beacon periods
    assign loss_point   = {14'd0, i_cfg.bcn_interval, 2'b00};
    assign reboot_point = {13'd0, i_cfg.bcn_interval, 3'b000};

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_item.opcode)
            OP_FAST_TICK: begin
                o_state.frame_ticks = frame_inc;
                if (!i_cfg.power_mode) begin
                    if (frame_inc == loss_point) begin
                        o_result.radio_reset_task = 1'b1;
                        o_result.enable_radio_irq = 1'b1;
                        o_result.wake_radio       = 1'b1;
                    end
                    if (frame_inc > reboot_point) begin
                        o_result.reboot_request = 1'b1;
                    end
                    if (frame_inc == i_cfg.pre_beacon_wake) begin
                        o_result.wake_radio       = 1'b1;
                        o_result.enable_radio_irq = 1'b1;
                    end
                    if (i_cfg.collect_enable && i_item.collect_active) begin
                        if (collect_inc == i_cfg.coll_interval) begin
                            o_state.collect_ticks = '0;
                            o_result.collect_data = 1'b1;
                        end else begin
                            o_state.collect_ticks = collect_inc;
                        end
                    end
                end
            end
            OP_SLOW_TICK: begin
                if (!i_cfg.power_mode) begin
                    o_state.silence_ticks = silence_inc;
                    if (silence_inc > i_cfg.reboot_limit) begin
                        o_result.reboot_request = 1'b1;
                    end else if (silence_inc > i_cfg.radio_reset_limit) begin
                        o_result.radio_reset_now  = 1'b1;
                        o_result.enable_radio_irq = 1'b1;
                    end
                end else begin
                    if (cal_inc == i_cfg.calib_interval) begin
                        o_state.cal_ticks  = '0;
                        o_result.calibrate = i_item.road_empty;
                    end else begin
                        o_state.cal_ticks = cal_inc;
                    end
                    o_result.get_variance = 1'b1;
                end
            end
            OP_PKT_IRQ: begin
                o_state.silence_ticks = '0;
                if (i_item.packet_valid) begin
                    o_result.packet_ok = 1'b1;
                    case (i_item.packet_type)
                        PKT_BEACON: begin
                            o_state.frame_ticks      = '0;
                            o_result.arm_frame_timer = 1'b1;
                            o_result.handler_event   = HE_BEACON;
                        end
                        PKT_JOIN_ACK: o_result.handler_event = HE_JOIN_ACK;
                        PKT_REJOIN:   o_result.handler_event = HE_REJOIN;
                        default:      o_result.handler_event = HE_NONE;
                    endcase
                end
            end
            default: begin
                o_state  = i_state;
                o_result = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/beacon_sync_supervisor_timer_unit.sv =====
// ----------------------------------------------------------------------------
// beacon_sync_supervisor_timer_unit
// Supervisor timer for a beacon-synchronised radio node.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one event per transfer: fast tick, slow tick or packet
//   interrupt. o_out returns exactly one request word per event, in order.
//   Registers are written over the APB-style port at byte address 4*index
//   and must only be changed while no event is in flight.
// Data path:
//   An accepted event is registered, evaluated against the counters in one
//   pass of short logic and loaded into the result register for o_out. One
//   event is taken every cycle unless o_out stalls; the counters update in
//   the same cycle the result register is loaded, so events run back to back.
// Stall behaviour:
//   The result register holds while o_out.ready is low. The input register
//   still takes one more event, then i_in.ready drops until the result is
//   taken. Nothing is lost or repeated.
// Reset:
//   Synchronous active-low i_rst_n clears both pipeline stages and all four
//   counters and returns the registers to their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module beacon_sync_supervisor_timer_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    bss_in_if.sink                      i_in,
    bss_out_if.source                   o_out,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [bss_pkg::ADDR_W-1:0]   paddr,
    input  wire [31:0]                  pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import bss_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_item;
    logic    r_item_valid;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    advance;
    logic    cfg_wr;
    logic [2:0] reg_idx;

    // register access
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_mode        <= 1'b0;
            r_cfg.bcn_interval      <= RST_BEACON_PER;
            r_cfg.pre_beacon_wake   <= RST_PRE_WAKE;
            r_cfg.coll_interval     <= RST_COLLECT_PER;
            r_cfg.collect_enable    <= 1'b1;
            r_cfg.calib_interval    <= RST_CAL_PER;
            r_cfg.radio_reset_limit <= RST_RRESET_LIMIT;
            r_cfg.reboot_limit      <= RST_REBOOT_LIMIT;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_POWER_MODE:   r_cfg.power_mode        <= pwdata[0];
                REG_BEACON_PER:   r_cfg.bcn_interval      <= pwdata[15:0];
                REG_PRE_WAKE:     r_cfg.pre_beacon_wake   <= pwdata;
                REG_COLLECT_PER:  r_cfg.coll_interval     <= pwdata[15:0];
                REG_COLLECT_EN:   r_cfg.collect_enable    <= pwdata[0];
                REG_CAL_PER:      r_cfg.calib_interval    <= pwdata[15:0];
                REG_RRESET_LIMIT: r_cfg.radio_reset_limit <= pwdata[15:0];
                REG_REBOOT_LIMIT: r_cfg.reboot_limit      <= pwdata[15:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        case (reg_idx)
            REG_POWER_MODE:   prdata = {31'd0, r_cfg.power_mode};
            REG_BEACON_PER:   prdata = {16'd0, r_cfg.bcn_interval};
            REG_PRE_WAKE:     prdata = r_cfg.pre_beacon_wake;
            REG_COLLECT_PER:  prdata = {16'd0, r_cfg.coll_interval};
            REG_COLLECT_EN:   prdata = {31'd0, r_cfg.collect_enable};
            REG_CAL_PER:      prdata = {16'd0, r_cfg.calib_interval};
            REG_RRESET_LIMIT: prdata = {16'd0, r_cfg.radio_reset_limit};
            REG_REBOOT_LIMIT: prdata = {16'd0, r_cfg.reboot_limit};
            default:          prdata = '0;
        endcase
    end

    // pipeline flow control
    assign advance    = r_item_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_item_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_item_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.opcode         <= i_in.opcode;
            r_item.packet_valid   <= i_in.packet_valid;
            r_item.packet_type    <= i_in.packet_type;
            r_item.collect_active <= i_in.collect_active;
            r_item.road_empty     <= i_in.road_empty;
        end
    end

    // event evaluation
    bss_step u_step (
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.reboot_request   = r_result.reboot_request;
    assign o_out.radio_reset_task = r_result.radio_reset_task;
    assign o_out.radio_reset_now  = r_result.radio_reset_now;
    assign o_out.wake_radio       = r_result.wake_radio;
    assign o_out.enable_radio_irq = r_result.enable_radio_irq;
    assign o_out.collect_data     = r_result.collect_data;
    assign o_out.calibrate        = r_result.calibrate;
    assign o_out.get_variance     = r_result.get_variance;
    assign o_out.handler_event    = r_result.handler_event;
    assign o_out.arm_frame_timer  = r_result.arm_frame_timer;
    assign o_out.packet_ok        = r_result.packet_ok;

    // checks
    a_hdl_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_result.handler_event != HE_NONE) |-> r_result.packet_ok)
        else $error("handler event without valid packet");

    a_silence_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.radio_reset_now |-> !r_result.reboot_request)
        else $error("hard radio reset raised together with reboot");

    a_cal_with_var: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.calibrate |-> r_result.get_variance)
        else $error("calibrate without variance request");

    a_arm_on_beacon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_result.arm_frame_timer |=> (r_state.frame_ticks == 32'd0))
        else $error("frame counter not cleared on beacon");

    a_pkt_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_item.opcode == OP_PKT_IRQ) |=> (r_state.silence_ticks == 16'd0))
        else $error("silence count not cleared by packet interrupt");

endmodule

`default_nettype wire
